### rtl/bfrb_pkg.sv
// ----------------------------------------------------------------------------
// bfrb_pkg - shared types and constants for the batch flush / retry backoff
// Request and result layouts, event codes, register indexes.
// ----------------------------------------------------------------------------
package bfrb_pkg;

  localparam int unsigned TIME_BITS  = 48;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned FILL_BITS  = 16;
  localparam int unsigned BYTE_BITS  = 32;
  localparam int unsigned SAMP_BITS  = 16;
  localparam int unsigned CODE_BITS  = 10;
  localparam int unsigned DELAY_BITS = 31;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [DELAY_BITS-1:0] AUTH_FLOOR_MS     = DELAY_BITS'(60000);
  localparam logic [CODE_BITS-1:0]  HTTP_UNAUTHORIZED = CODE_BITS'(401);
  localparam logic [CODE_BITS-1:0]  HTTP_FORBIDDEN    = CODE_BITS'(403);

  typedef enum logic [1:0] {
    FUNC_SUBMIT = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BATCH_LIMIT   = 3'd0,
    CFG_FLUSH_AGE     = 3'd1,
    CFG_PAYLOAD_LIMIT = 3'd2,
    CFG_RETRY_FIRST   = 3'd3,
    CFG_RETRY_CAP     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [FILL_BITS-1:0]  batch_limit;
    logic [DELAY_BITS-1:0] flush_age;
    logic [BYTE_BITS-1:0]  payload_limit;
    logic [DELAY_BITS-1:0] retry_first;
    logic [DELAY_BITS-1:0] retry_cap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [TIME_BITS-1:0] now_ms;
    logic [SAMP_BITS-1:0] sample_bytes;
    logic                 send_ok;
    logic [CODE_BITS-1:0] resp_code;
  } req_t;

  typedef struct packed {
    logic                  accepted;
    logic                  send_attempted;
    logic                  batch_dropped;
    logic [FILL_BITS-1:0]  buffered_count;
    logic                  pending;
    logic [TIME_BITS-1:0]  retry_at_ms;
    logic [COUNT_BITS-1:0] sent_count;
    logic [COUNT_BITS-1:0] failure_count;
    logic [COUNT_BITS-1:0] dropped_sample_count;
    logic [COUNT_BITS-1:0] dropped_batch_count;
  } res_t;

  // handshake between the request register and the update stage
  typedef struct packed {
    logic advance;
  } stage_t;

endpackage

### rtl/bfrb_cfg_regs.sv
// ----------------------------------------------------------------------------
// bfrb_cfg_regs - configuration register file
// Write-only registers, taken when the write enable is high.
// ----------------------------------------------------------------------------
module bfrb_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bfrb_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [bfrb_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output bfrb_pkg::cfg_t                       cfg_o
);

  bfrb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfrb_pkg::CFG_BATCH_LIMIT:
          cfg_d.batch_limit = cfg_data_i[bfrb_pkg::FILL_BITS-1:0];
        bfrb_pkg::CFG_FLUSH_AGE:
          cfg_d.flush_age = cfg_data_i[bfrb_pkg::DELAY_BITS-1:0];
        bfrb_pkg::CFG_PAYLOAD_LIMIT:
          cfg_d.payload_limit = cfg_data_i[bfrb_pkg::BYTE_BITS-1:0];
        bfrb_pkg::CFG_RETRY_FIRST:
          cfg_d.retry_first = cfg_data_i[bfrb_pkg::DELAY_BITS-1:0];
        bfrb_pkg::CFG_RETRY_CAP:
          cfg_d.retry_cap = cfg_data_i[bfrb_pkg::DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.batch_limit   <= bfrb_pkg::FILL_BITS'(256);
      cfg_q.flush_age     <= bfrb_pkg::DELAY_BITS'(1000);
      cfg_q.payload_limit <= bfrb_pkg::BYTE_BITS'(1048576);
      cfg_q.retry_first   <= bfrb_pkg::DELAY_BITS'(1000);
      cfg_q.retry_cap     <= bfrb_pkg::DELAY_BITS'(60000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/bfrb_in_stage.sv
// ----------------------------------------------------------------------------
// bfrb_in_stage - request register
// Holds one request until the update stage takes it.
// ----------------------------------------------------------------------------
module bfrb_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bfrb_pkg::req_t  req_i,
  input  logic            advance_i,
  output bfrb_pkg::stage_t stage_o,
  output bfrb_pkg::req_t  req_o
);

  logic           valid_q, valid_d;
  logic           load;
  bfrb_pkg::req_t req_q;

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign stage_o.advance = valid_q & advance_i;
  assign req_o           = req_q;

endmodule

### rtl/bfrb_core.sv
// ----------------------------------------------------------------------------
// bfrb_core - batch and backoff state with single-pass update
// Applies one request per cycle, while the stage advances, to the batch, retry and counter state.
// ----------------------------------------------------------------------------
module bfrb_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bfrb_pkg::cfg_t   cfg_i,
  input  bfrb_pkg::stage_t stage_i,
  input  bfrb_pkg::req_t   req_i,
  output bfrb_pkg::res_t   res_o
);

  localparam int unsigned TB = bfrb_pkg::TIME_BITS;
  localparam int unsigned CB = bfrb_pkg::COUNT_BITS;
  localparam int unsigned FB = bfrb_pkg::FILL_BITS;
  localparam int unsigned BB = bfrb_pkg::BYTE_BITS;
  localparam int unsigned DB = bfrb_pkg::DELAY_BITS;

  function automatic logic [CB-1:0] bump(input logic [CB-1:0] c);
    return (&c) ? c : c + CB'(1);
  endfunction

  logic [FB-1:0] fill_q, fill_d;
  logic [BB-1:0] bytes_q, bytes_d;
  logic [TB-1:0] first_q, first_d;
  logic          pend_q, pend_d;
  logic          active_q, active_d;
  logic [DB-1:0] delay_q, delay_d;
  logic [TB-1:0] retry_q, retry_d;
  logic [CB-1:0] sent_q, sent_d;
  logic [CB-1:0] fail_q, fail_d;
  logic [CB-1:0] refused_q, refused_d;
  logic [CB-1:0] discard_q, discard_d;

  // backoff plan for a failure on this request
  logic [DB:0]   dbl;
  logic [DB-1:0] capped, base, delay_new;
  logic          auth;
  logic [TB:0]   retry_sum;
  logic [TB-1:0] retry_new;

  logic [TB:0]   age;
  logic          due, retry_due;
  logic [BB:0]   byte_sum;
  logic          do_retry, do_flush;
  logic          accepted, attempted, dropped;

  always_comb begin
    dbl       = {delay_q, 1'b0};
    capped    = (dbl < {1'b0, cfg_i.retry_cap}) ? dbl[DB-1:0] : cfg_i.retry_cap;
    base      = active_q ? capped : cfg_i.retry_first;
    auth      = (req_i.resp_code == bfrb_pkg::HTTP_UNAUTHORIZED) ||
                (req_i.resp_code == bfrb_pkg::HTTP_FORBIDDEN);
    delay_new = (auth && base < bfrb_pkg::AUTH_FLOOR_MS) ? bfrb_pkg::AUTH_FLOOR_MS : base;
    retry_sum = {1'b0, req_i.now_ms} + (TB+1)'(delay_new);
    retry_new = retry_sum[TB] ? {TB{1'b1}} : retry_sum[TB-1:0];

    age       = {1'b0, req_i.now_ms} - {1'b0, first_q};
    due       = (fill_q >= cfg_i.batch_limit) ||
                (!age[TB] && age[TB-1:0] >= TB'(cfg_i.flush_age));
    retry_due = req_i.now_ms >= retry_q;
    byte_sum  = {1'b0, bytes_q} + (BB+1)'(req_i.sample_bytes);
  end

  always_comb begin
    fill_d    = fill_q;
    bytes_d   = bytes_q;
    first_d   = first_q;
    pend_d    = pend_q;
    active_d  = active_q;
    delay_d   = delay_q;
    retry_d   = retry_q;
    sent_d    = sent_q;
    fail_d    = fail_q;
    refused_d = refused_q;
    discard_d = discard_q;
    accepted  = 1'b0;
    attempted = 1'b0;
    dropped   = 1'b0;
    do_retry  = 1'b0;
    do_flush  = 1'b0;

    unique case (req_i.func)
      bfrb_pkg::FUNC_SUBMIT: begin
        if (pend_q) begin
          refused_d = bump(refused_q);
        end else begin
          if (fill_q == '0) begin
            first_d = req_i.now_ms;
          end
          if (fill_q >= cfg_i.batch_limit) begin
            refused_d = bump(refused_q);
          end else begin
            fill_d   = fill_q + FB'(1);
            bytes_d  = byte_sum[BB] ? {BB{1'b1}} : byte_sum[BB-1:0];
            accepted = 1'b1;
          end
        end
      end
      bfrb_pkg::FUNC_TICK: begin
        if (pend_q) begin
          do_retry = retry_due;
        end else begin
          do_flush = (fill_q != '0) && due;
        end
      end
      bfrb_pkg::FUNC_FLUSH: begin
        do_retry = pend_q;
        do_flush = !pend_q && (fill_q != '0);
      end
      default: ;
    endcase

    if (do_flush && bytes_q > cfg_i.payload_limit) begin
      discard_d = bump(discard_q);
      fill_d    = '0;
      bytes_d   = '0;
      first_d   = '0;
      dropped   = 1'b1;
    end else if (do_retry || do_flush) begin
      attempted = 1'b1;
      if (do_flush) begin
        fill_d  = '0;
        bytes_d = '0;
        first_d = '0;
      end
      if (req_i.send_ok) begin
        sent_d   = bump(sent_q);
        pend_d   = 1'b0;
        active_d = 1'b0;
        delay_d  = '0;
        retry_d  = '0;
      end else begin
        fail_d   = bump(fail_q);
        pend_d   = 1'b1;
        active_d = 1'b1;
        delay_d  = delay_new;
        retry_d  = retry_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      bytes_q   <= '0;
      first_q   <= '0;
      pend_q    <= 1'b0;
      active_q  <= 1'b0;
      delay_q   <= '0;
      retry_q   <= '0;
      sent_q    <= '0;
      fail_q    <= '0;
      refused_q <= '0;
      discard_q <= '0;
    end else if (stage_i.advance) begin
      fill_q    <= fill_d;
      bytes_q   <= bytes_d;
      first_q   <= first_d;
      pend_q    <= pend_d;
      active_q  <= active_d;
      delay_q   <= delay_d;
      retry_q   <= retry_d;
      sent_q    <= sent_d;
      fail_q    <= fail_d;
      refused_q <= refused_d;
      discard_q <= discard_d;
    end
  end

  assign res_o.accepted             = accepted;
  assign res_o.send_attempted       = attempted;
  assign res_o.batch_dropped        = dropped;
  assign res_o.buffered_count       = fill_d;
  assign res_o.pending              = pend_d;
  assign res_o.retry_at_ms          = retry_d;
  assign res_o.sent_count           = sent_d;
  assign res_o.failure_count        = fail_d;
  assign res_o.dropped_sample_count = refused_d;
  assign res_o.dropped_batch_count  = discard_d;

endmodule

### rtl/bfrb_out_stage.sv
// ----------------------------------------------------------------------------
// bfrb_out_stage - result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module bfrb_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bfrb_pkg::stage_t stage_i,
  input  bfrb_pkg::res_t   res_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bfrb_pkg::res_t   res_o
);

  logic           valid_q, valid_d;
  bfrb_pkg::res_t res_q;

  assign advance_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (stage_i.advance) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.advance) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### rtl/batch_flush_retry_backoff.sv
// ----------------------------------------------------------------------------
// batch_flush_retry_backoff - batching uplink control with retry backoff
// Path: request register, then one update pass into the result register.
// Throughput: 1 request per cycle while the output is not stalled; the state update is a single pass.
// Reset: batch, backoff and counters clear to zero; registers take defaults.
// ----------------------------------------------------------------------------
module batch_flush_retry_backoff (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bfrb_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [bfrb_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          func_i,
  input  logic [bfrb_pkg::TIME_BITS-1:0]      now_ms_i,
  input  logic [bfrb_pkg::SAMP_BITS-1:0]      sample_bytes_i,
  input  logic                                send_ok_i,
  input  logic [bfrb_pkg::CODE_BITS-1:0]      resp_code_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                accepted_o,
  output logic                                send_attempted_o,
  output logic                                batch_dropped_o,
  output logic [bfrb_pkg::FILL_BITS-1:0]      buffered_count_o,
  output logic                                pending_o,
  output logic [bfrb_pkg::TIME_BITS-1:0]      retry_at_ms_o,
  output logic [bfrb_pkg::COUNT_BITS-1:0]     sent_count_o,
  output logic [bfrb_pkg::COUNT_BITS-1:0]     failure_count_o,
  output logic [bfrb_pkg::COUNT_BITS-1:0]     dropped_sample_count_o,
  output logic [bfrb_pkg::COUNT_BITS-1:0]     dropped_batch_count_o
);

  bfrb_pkg::cfg_t   cfg;
  bfrb_pkg::req_t   req_in, req;
  bfrb_pkg::res_t   res_next, res;
  bfrb_pkg::stage_t stage;
  logic             advance;

  assign req_in.func         = func_i;
  assign req_in.now_ms       = now_ms_i;
  assign req_in.sample_bytes = sample_bytes_i;
  assign req_in.send_ok      = send_ok_i;
  assign req_in.resp_code    = resp_code_i;

  bfrb_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  bfrb_in_stage u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .req_i     (req_in),
    .advance_i (advance),
    .stage_o   (stage),
    .req_o     (req)
  );

  bfrb_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i   (cfg),
    .stage_i (stage),
    .req_i   (req),
    .res_o   (res_next)
  );

  bfrb_out_stage u_out (
    .clk_i,
    .rst_ni,
    .stage_i   (stage),
    .res_i     (res_next),
    .advance_o (advance),
    .out_valid_o,
    .out_stall_i,
    .res_o     (res)
  );

  assign accepted_o             = res.accepted;
  assign send_attempted_o       = res.send_attempted;
  assign batch_dropped_o        = res.batch_dropped;
  assign buffered_count_o       = res.buffered_count;
  assign pending_o              = res.pending;
  assign retry_at_ms_o          = res.retry_at_ms;
  assign sent_count_o           = res.sent_count;
  assign failure_count_o        = res.failure_count;
  assign dropped_sample_count_o = res.dropped_sample_count;
  assign dropped_batch_count_o  = res.dropped_batch_count;

endmodule
